FILE: hw/rtl/pwmlm_pkg.sv
package pwmlm_pkg;

    localparam logic [7:0] FULL_LEVEL = 8'd255;

    // Auto-white mode codes, shared by the strip and the global setting.
    localparam logic [2:0] WM_MANUAL   = 3'd0;
    localparam logic [2:0] WM_BRIGHTER = 3'd1;
    localparam logic [2:0] WM_ACCURATE = 3'd2;
    localparam logic [2:0] WM_DUAL     = 3'd3;
    localparam logic [2:0] WM_MAX      = 3'd4;
    localparam logic [2:0] WM_OFF      = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_STRIP_WHITE_MODE  = 3'd0;
    localparam logic [2:0] REG_GLOBAL_WHITE_MODE = 3'd1;
    localparam logic [2:0] REG_CCT_LEVEL         = 3'd2;
    localparam logic [2:0] REG_CCT_BLEND         = 3'd3;
    localparam logic [2:0] REG_CHANNEL_COUNT     = 3'd4;
    localparam logic [2:0] REG_BRIGHTNESS        = 3'd5;
    localparam logic [2:0] REG_INVERT_OUTPUT     = 3'd6;

    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_SHOW = 1'b1;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } lane_op_t;

    typedef struct packed {
        logic     start;
        lane_op_t op;
    } lane_cmd_t;

    // Exact x / 255 for any x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

FILE: hw/rtl/pwmlm_if.sv
interface pwmlm_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] pixel_index;
    logic [31:0] color_rgbw;

    modport source (output valid, output mode, output pixel_index, output color_rgbw,
                    input ready);
    modport sink (input valid, input mode, input pixel_index, input color_rgbw,
                  output ready);
endinterface

interface pwmlm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  duty_a;
    logic [7:0]  duty_b;
    logic [7:0]  duty_c;
    logic [7:0]  duty_d;
    logic [7:0]  duty_e;
    logic [31:0] stored_color;

    modport source (output valid, output duty_a, output duty_b, output duty_c,
                    output duty_d, output duty_e, output stored_color, input ready);
    modport sink (input valid, input duty_a, input duty_b, input duty_c,
                  input duty_d, input duty_e, input stored_color, output ready);
endinterface

interface pwmlm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/pwmlm_lane.sv
module pwmlm_lane import pwmlm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lane_cmd_t   cmd,
    input  logic [15:0] a,
    input  logic [7:0]  b,
    output logic        busy,
    output logic [15:0] result
);

    logic           busy_reg;
    logic [3:0]     cnt_reg;
    lane_op_t       op_reg;
    logic [7:0]     opnd_reg;
    logic [7:0]     rem_reg;
    logic [15:0]    q_reg;
    logic [7:0]     rem_next;
    logic [15:0]    q_next;
    logic [8:0]     trial;
    logic           ge;
    logic [8:0]     sum;

    // Division: restoring, one quotient bit per cycle, dividend shifted out of
    // the top of q_reg while quotient bits enter at the bottom.
    // Multiplication: shift-add, one multiplier bit per cycle from the bottom.
    always_comb
    begin
        trial = {rem_reg, q_reg[15]};
        ge    = trial >= {1'b0, opnd_reg};
        sum   = {1'b0, rem_reg} + (q_reg[0] ? {1'b0, opnd_reg} : 9'd0);
        unique case (op_reg)
            OP_DIV:
            begin
                rem_next = ge ? 8'(trial - {1'b0, opnd_reg}) : trial[7:0];
                q_next   = {q_reg[14:0], ge};
            end
            OP_MUL:
            begin
                rem_next = sum[8:1];
                q_next   = {q_reg[15:8], sum[0], q_reg[7:1]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
            op_reg   <= OP_MUL;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            op_reg   <= cmd.op;
            cnt_reg  <= (cmd.op == OP_DIV) ? 4'd15 : 4'd7;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            opnd_reg <= (cmd.op == OP_DIV) ? b : a[7:0];
            rem_reg  <= 8'd0;
            q_reg    <= (cmd.op == OP_DIV) ? a : {8'd0, b};
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy   = busy_reg;
    assign result = (op_reg == OP_DIV) ? q_reg : {rem_reg, q_reg[7:0]};

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("lane started while still busy");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(cnt_reg) == 4'd0)
        else $error("lane finished before its last step");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && op_reg == OP_DIV && !cmd.start && !$rose(busy_reg))
            |-> rem_reg < opnd_reg)
        else $error("division remainder not below divisor");

endmodule

FILE: hw/rtl/pwm_led_channel_mixer_unit.sv
// PWM light channel mixer. A set item for pixel 0 derives white, splits it into
// warm and cold levels and stores the channel levels; the serial lanes do the
// work: a restoring division by the blend denominator at one quotient bit per
// cycle, followed by a shift-add scaling of white at one multiplier bit per
// cycle. A set item for another pixel, or for an unsupported light type, is
// taken and changes nothing. A show item runs the 8-step brightness multiply in
// one lane per channel; a new item is taken only while the mixer is idle, and a
// show result waits until the output register is free, then is held there until
// taken, so a further show item can be taken but cannot finish before that.
module pwm_led_channel_mixer_unit import pwmlm_pkg::*;
#(
    parameter int MAX_CHANNELS = 5
)
(
    input  logic  clk,
    input  logic  rst_n,
    pwmlm_cfg_if.sink  cfg,
    pwmlm_in_if.sink   pixel,
    pwmlm_out_if.source result
);

    localparam int NUM_LANES = (MAX_CHANNELS < 2) ? 2 : MAX_CHANNELS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WMUL = 2'd2;
    localparam logic [1:0] S_SHOW = 2'd3;

    logic [2:0] strip_white_mode_reg;
    logic [2:0] global_white_mode_reg;
    logic [7:0] cct_level_reg;
    logic [6:0] cct_blend_reg;
    logic [2:0] channel_count_reg;
    logic [7:0] brightness_reg;
    logic       invert_output_reg;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [7:0] level_reg [MAX_CHANNELS];
    logic [7:0] lvl_view [5];
    logic [7:0] r_reg, g_reg, b_reg, w_reg;
    logic       out_valid_reg;
    logic [7:0] duty_reg [5];
    logic [31:0] stored_color_reg;

    logic        in_fire;
    logic        out_free;
    logic        type_ok;
    logic [2:0]  active;
    logic [31:0] colour_mixed;
    logic [7:0]  den;
    logic [7:0]  warm_span;
    logic [15:0] ww_num, cw_num;
    logic [7:0]  ww_sel, cw_sel;
    logic [7:0]  ww_lvl, cw_lvl;
    logic        start_div, start_wmul, start_show;
    logic        lane_busy;
    logic        set_done, show_done;
    logic [NUM_LANES-1:0] busy_vec;
    logic [15:0] lane_res [NUM_LANES];
    logic [15:0] prod [5];
    logic [7:0]  new_level [5];
    logic [4:0]  level_we;
    logic [7:0]  duty_next [5];

    function automatic logic [31:0] auto_white(input logic [31:0] c, input logic [2:0] sm,
                                               input logic [2:0] gm);
        logic [2:0] m;
        logic [7:0] r, g, b, w, mn, mx;
        logic [31:0] res;
        m  = (gm < WM_OFF) ? gm : sm;
        w  = c[31:24];
        r  = c[23:16];
        g  = c[15:8];
        b  = c[7:0];
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        if (m == WM_MANUAL || (w != 8'd0 && m == WM_DUAL))
        begin
            res = c;
        end
        else if (m == WM_MAX)
        begin
            res = {mx, r, g, b};
        end
        else if (m == WM_ACCURATE)
        begin
            res = {mn, r - mn, g - mn, b - mn};
        end
        else
        begin
            // Brighter, dual with no white, and the unused codes.
            res = {mn, r, g, b};
        end
        return res;
    endfunction

    assign in_fire  = pixel.valid && pixel.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign type_ok  = (channel_count_reg >= 3'd1) && (channel_count_reg <= 3'd5)
                      && (channel_count_reg <= 3'(MAX_CHANNELS));
    assign active   = type_ok ? channel_count_reg : 3'd0;

    assign pixel.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    assign colour_mixed = (channel_count_reg == 3'd3) ? pixel.color_rgbw
        : auto_white(pixel.color_rgbw, strip_white_mode_reg, global_white_mode_reg);

    assign den       = FULL_LEVEL - {1'b0, cct_blend_reg};
    assign warm_span = FULL_LEVEL - cct_level_reg;
    assign ww_num    = {warm_span, 8'd0} - {8'd0, warm_span};
    assign cw_num    = {cct_level_reg, 8'd0} - {8'd0, cct_level_reg};
    assign ww_sel    = (cct_level_reg < {1'b0, cct_blend_reg}) ? FULL_LEVEL : lane_res[0][7:0];
    assign cw_sel    = (warm_span < {1'b0, cct_blend_reg}) ? FULL_LEVEL : lane_res[1][7:0];

    assign lane_busy  = busy_vec[0];
    assign start_div  = in_fire && pixel.mode == MODE_SET && pixel.pixel_index == 16'd0
                        && type_ok;
    assign start_wmul = (state_reg == S_DIV) && !lane_busy;
    assign start_show = in_fire && pixel.mode == MODE_SHOW;
    assign set_done   = (state_reg == S_WMUL) && !lane_busy;
    assign show_done  = (state_reg == S_SHOW) && !lane_busy && out_free;

    generate
        for (genvar i = 0; i < NUM_LANES; i++)
        begin : g_lane
            lane_cmd_t   cmd;
            logic [15:0] lane_a;
            logic [7:0]  lane_b;
            logic [7:0]  show_lvl;

            assign show_lvl = (i < 5) ? lvl_view[(i < 5) ? i : 0] : 8'd0;

            always_comb
            begin
                cmd.start = start_div || start_wmul || start_show;
                cmd.op    = start_div ? OP_DIV : OP_MUL;
                if (start_div)
                begin
                    lane_a = (i == 1) ? cw_num : ww_num;
                    lane_b = den;
                end
                else if (start_wmul)
                begin
                    lane_a = {8'd0, w_reg};
                    lane_b = (i == 1) ? cw_sel : ww_sel;
                end
                else
                begin
                    lane_a = {8'd0, show_lvl};
                    lane_b = brightness_reg;
                end
            end

            pwmlm_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .cmd    (cmd),
                .a      (lane_a),
                .b      (lane_b),
                .busy   (busy_vec[i]),
                .result (lane_res[i])
            );
        end

        for (genvar i = 0; i < 5; i++)
        begin : g_view
            if (i < MAX_CHANNELS)
            begin : g_have
                assign lvl_view[i] = level_reg[i];
            end
            else
            begin : g_none
                assign lvl_view[i] = 8'd0;
            end
            if (i < NUM_LANES)
            begin : g_prod
                assign prod[i] = lane_res[i];
            end
            else
            begin : g_noprod
                assign prod[i] = 16'd0;
            end
        end
    endgenerate

    assign ww_lvl = div255(lane_res[0]);
    assign cw_lvl = div255(lane_res[1]);

    always_comb
    begin
        new_level[0] = r_reg;
        new_level[1] = g_reg;
        new_level[2] = b_reg;
        new_level[3] = w_reg;
        new_level[4] = cw_lvl;
        level_we     = 5'b00000;
        unique case (channel_count_reg)
            3'd1:
            begin
                new_level[0] = w_reg;
                level_we     = 5'b00001;
            end
            3'd2:
            begin
                new_level[0] = ww_lvl;
                new_level[1] = cw_lvl;
                level_we     = 5'b00011;
            end
            3'd3:
            begin
                level_we = 5'b00111;
            end
            3'd4:
            begin
                level_we = 5'b01111;
            end
            3'd5:
            begin
                new_level[3] = ww_lvl;
                level_we     = 5'b11111;
            end
            default:
            begin
                level_we = 5'b00000;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            logic [7:0] q;
            q = div255(prod[i]);
            if (3'(i) < active)
            begin
                duty_next[i] = invert_output_reg ? FULL_LEVEL - q : q;
            end
            else
            begin
                duty_next[i] = 8'd0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_div)
                begin
                    state_next = S_DIV;
                end
                else if (start_show)
                begin
                    state_next = S_SHOW;
                end
            end
            S_DIV:
            begin
                if (start_wmul)
                begin
                    state_next = S_WMUL;
                end
            end
            S_WMUL:
            begin
                if (set_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHOW:
            begin
                if (show_done)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_white_mode_reg  <= WM_MANUAL;
            global_white_mode_reg <= WM_OFF;
            cct_level_reg         <= 8'd0;
            cct_blend_reg         <= 7'd0;
            channel_count_reg     <= 3'd3;
            brightness_reg        <= FULL_LEVEL;
            invert_output_reg     <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_STRIP_WHITE_MODE:  strip_white_mode_reg  <= cfg.data[2:0];
                REG_GLOBAL_WHITE_MODE: global_white_mode_reg <= cfg.data[2:0];
                REG_CCT_LEVEL:         cct_level_reg         <= cfg.data;
                REG_CCT_BLEND:         cct_blend_reg         <= cfg.data[6:0];
                REG_CHANNEL_COUNT:     channel_count_reg     <= cfg.data[2:0];
                REG_BRIGHTNESS:        brightness_reg        <= cfg.data;
                REG_INVERT_OUTPUT:     invert_output_reg     <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                level_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (show_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (set_done)
            begin
                for (int i = 0; i < MAX_CHANNELS; i++)
                begin
                    if (level_we[i])
                    begin
                        level_reg[i] <= new_level[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_div)
        begin
            w_reg <= colour_mixed[31:24];
            r_reg <= colour_mixed[23:16];
            g_reg <= colour_mixed[15:8];
            b_reg <= colour_mixed[7:0];
        end
        if (show_done)
        begin
            for (int i = 0; i < 5; i++)
            begin
                duty_reg[i] <= duty_next[i];
            end
            stored_color_reg <= {lvl_view[3], lvl_view[0], lvl_view[1], lvl_view[2]};
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.duty_a       = duty_reg[0];
    assign result.duty_b       = duty_reg[1];
    assign result.duty_c       = duty_reg[2];
    assign result.duty_d       = duty_reg[3];
    assign result.duty_e       = duty_reg[4];
    assign result.stored_color = stored_color_reg;

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_vec == {NUM_LANES{busy_vec[0]}})
        else $error("lanes out of step");

    a_result_from_show: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_SHOW)
        else $error("result raised outside a show");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        show_done |-> (!out_valid_reg || result.ready))
        else $error("pending result overwritten");

    a_busy_outside_idle: assert property (@(posedge clk) disable iff (!rst_n)
        lane_busy |-> state_reg != S_IDLE)
        else $error("lanes busy while idle");

endmodule
